// ===== rtl/rgbm_pkg.sv =====
// Package for the running Gaussian background model.
// Shared widths, register indexes, phase codes and interface structs.
// No dependencies.
`default_nettype none

package rgbm_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int LEN_W      = IDX_W + 1;
    localparam int PIX_W      = 16;
    localparam int VAR_W      = 24;
    localparam int MOM_W      = 32;
    localparam int FC_W       = 8;
    localparam int LIM_W      = 25;
    localparam int WORD_W     = PIX_W + VAR_W + MOM_W;

    // stages between the memory read and the write back
    localparam int PRE_STAGES = 20;

    localparam logic [VAR_W-1:0] VAR_FLOOR = 24'd655;
    localparam logic [VAR_W-1:0] VAR_MAX   = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_PIXELS = 3'd0;
    localparam logic [2:0] REG_WARMUP       = 3'd1;
    localparam logic [2:0] REG_THRESHOLD    = 3'd2;
    localparam logic [2:0] REG_RATE         = 3'd3;
    localparam logic [2:0] REG_OCCL_PCT     = 3'd4;

    localparam logic [LEN_W-1:0] RST_FRAME_PIXELS = 17'd65536;
    localparam logic [FC_W-1:0]  RST_WARMUP       = 8'd40;
    localparam logic [15:0]      RST_THRESHOLD    = 16'd12288;
    localparam logic [15:0]      RST_RATE         = 16'd459;
    localparam logic [6:0]       RST_OCCL_PCT     = 7'd20;

    // model phase of an item
    localparam logic [1:0] PH_SEED = 2'd0;
    localparam logic [1:0] PH_WARM = 2'd1;
    localparam logic [1:0] PH_CONT = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [PIX_W-1:0] x;
        logic [1:0]              phase;
        logic                    last;
        logic                    warm;
        logic [7:0]              div;
    } front_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } wr_t;

    typedef struct packed {
        logic outlier;
        logic last;
        logic occl;
        logic warm;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/rgbm_calc.sv =====
// Arithmetic pipeline of the background model: read data in, write back and result out.
// Depends on rgbm_pkg.
`default_nettype none

module rgbm_calc
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire rgbm_pkg::front_t              in_item,
    input  wire logic [rgbm_pkg::WORD_W-1:0]   rdata,
    input  wire logic [31:0]                   t2,
    input  wire logic [15:0]                   rate,
    input  wire logic [rgbm_pkg::LIM_W-1:0]    occl_lim,
    output logic                               busy,
    output rgbm_pkg::wr_t                      wr,
    output logic                               out_valid,
    output rgbm_pkg::res_t                     out_res
);

    localparam int NST = rgbm_pkg::PRE_STAGES;

    typedef struct packed {
        logic [rgbm_pkg::IDX_W-1:0]  idx;
        logic signed [15:0]          x;
        logic [1:0]                  phase;
        logic                        last;
        logic                        warm;
        logic                        occl;
        logic                        inl;
        logic [7:0]                  div;
        logic signed [15:0]          mu;
        logic signed [15:0]          mu_w;
        logic signed [15:0]          mu_c;
        logic [23:0]                 vr;
        logic [23:0]                 var_c;
        logic [31:0]                 mom;
        logic [31:0]                 m;
        logic [22:0]                 sq16;
        logic [22:0]                 msq;
        logic signed [16:0]          d;
        logic [31:0]                 ad2;
        logic [39:0]                 plo;
        logic [39:0]                 phi;
        logic signed [29:0]          pdw;
        logic signed [33:0]          pda;
        logic [40:0]                 pva;
        logic [39:0]                 pvb;
        logic [31:0]                 num;
        logic [7:0]                  rem;
    } item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] mu;
        logic [23:0]        vr;
        logic [1:0]         phase;
        logic               last;
        logic               warm;
        logic               occl;
    } fin_t;

    typedef struct packed {
        logic [31:0] ad2;
        logic [39:0] plo;
        logic [39:0] phi;
        logic [1:0]  phase;
        logic        last;
        logic        warm;
        logic        occl;
    } tail_t;

    function automatic logic signed [19:0] rs16(input logic signed [34:0] v);
        logic [34:0] av;
        logic [35:0] r;
        av = v[34] ? 35'(-v) : 35'(v);
        r  = (36'(av) + 36'd32768) >> 16;
        return v[34] ? -$signed({1'b0, r[18:0]}) : $signed({1'b0, r[18:0]});
    endfunction

    function automatic logic signed [15:0] clamp_mean(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'sh7FFF;
        if (v < -21'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [23:0] clamp_var(input logic signed [33:0] v);
        if (v < $signed({10'd0, rgbm_pkg::VAR_FLOOR}))
            return rgbm_pkg::VAR_FLOOR;
        if (v > $signed({10'd0, rgbm_pkg::VAR_MAX}))
            return rgbm_pkg::VAR_MAX;
        return v[23:0];
    endfunction

    // two restoring division steps
    function automatic logic [39:0] div2(input logic [31:0] num, input logic [7:0] rem,
                                         input logic [7:0] dv);
        logic [31:0] n;
        logic [7:0]  r;
        logic [8:0]  t;
        n = num;
        r = rem;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, n[31]};
            if (t >= {1'b0, dv})
            begin
                r = 8'(t - {1'b0, dv});
                n = {n[30:0], 1'b1};
            end
            else
            begin
                r = t[7:0];
                n = {n[30:0], 1'b0};
            end
        end
        return {r, n};
    endfunction

    item_t            st_reg [NST];
    item_t            st_next [NST];
    logic [NST-1:0]   v_reg;
    fin_t             e_reg, e_next;
    logic             ev_reg;
    tail_t            f_reg, f_next;
    logic             fv_reg;
    logic [16:0]      cnt_reg, cnt_next;
    logic             occl_c;
    rgbm_pkg::res_t   res_next;

    logic [15:0] a_ax, a_amu, a_ad;
    logic [31:0] a_sq, a_msq;
    logic signed [16:0] a_d;
    logic [56:0] b_sum;
    logic [40:0] b_thr;
    logic [32:0] b_msum;
    logic [41:0] c_nv;
    logic [31:0] e_q;
    logic [23:0] e_vw;
    logic signed [16:0] f_d;
    logic [15:0] f_ad;
    logic [56:0] g_sum;
    logic [40:0] g_thr;

    assign busy = |v_reg;

    always_comb
    begin
        // stage A: fresh item and its memory word
        st_next[0] = '0;
        st_next[0].idx   = in_item.idx;
        st_next[0].x     = in_item.x;
        st_next[0].phase = in_item.phase;
        st_next[0].last  = in_item.last;
        st_next[0].warm  = in_item.warm;
        st_next[0].div   = in_item.div;

        // stage B: squares, difference, old threshold partials
        st_next[1] = st_reg[0];
        st_next[1].mu  = $signed(rdata[15:0]);
        st_next[1].vr  = rdata[39:16];
        st_next[1].mom = rdata[71:40];
        a_ax  = st_reg[0].x[15] ? 16'(-st_reg[0].x) : 16'(st_reg[0].x);
        a_amu = rdata[15] ? 16'(-$signed(rdata[15:0])) : rdata[15:0];
        a_sq  = 32'(a_ax) * 32'(a_ax);
        a_msq = 32'(a_amu) * 32'(a_amu);
        a_d   = $signed({st_reg[0].x[15], st_reg[0].x}) - $signed({rdata[15], rdata[15:0]});
        a_ad  = a_d[16] ? 16'(-a_d) : 16'(a_d);
        st_next[1].sq16 = a_sq[30:8];
        st_next[1].msq  = a_msq[30:8];
        st_next[1].d    = a_d;
        st_next[1].ad2  = 32'(a_ad) * 32'(a_ad);
        st_next[1].plo  = 40'(t2[15:0]) * 40'(rdata[39:16]);
        st_next[1].phi  = 40'(t2[31:16]) * 40'(rdata[39:16]);

        // stage C: inlier test on the old model, update products
        st_next[2] = st_reg[1];
        b_sum = 57'(st_reg[1].plo) + (57'(st_reg[1].phi) << 16) + 57'hFFFF;
        b_thr = b_sum[56:16];
        st_next[2].inl = 41'(st_reg[1].ad2) < b_thr;
        st_next[2].pdw = 30'(st_reg[1].d) * 30'sd6554;
        st_next[2].pda = 34'(st_reg[1].d) * $signed({18'd0, rate});
        st_next[2].pvb = 40'(rate) * 40'(st_reg[1].ad2[31:8]);
        st_next[2].pva = 41'(17'h10000 - {1'b0, rate}) * 41'(st_reg[1].vr);
        b_msum = 33'(st_reg[1].mom) + 33'(st_reg[1].sq16);
        st_next[2].m = b_msum[32] ? 32'hFFFFFFFF : b_msum[31:0];

        // stage D: candidate means and blended variance, divider input
        st_next[3] = st_reg[2];
        st_next[3].mu_w = clamp_mean(21'(st_reg[2].mu) + 21'(rs16(35'(st_reg[2].pdw))));
        st_next[3].mu_c = clamp_mean(21'(st_reg[2].mu) + 21'(rs16(35'(st_reg[2].pda))));
        c_nv = (42'(st_reg[2].pva) + 42'(st_reg[2].pvb) + 42'd32768) >> 16;
        st_next[3].var_c = clamp_var($signed({8'd0, c_nv[25:0]}));
        st_next[3].num   = st_reg[2].m;
        st_next[3].rem   = '0;
        st_next[3].occl  = occl_c;

        // divider: two quotient bits per stage
        for (int k = 4; k < NST; k++)
        begin
            st_next[k] = st_reg[k-1];
            {st_next[k].rem, st_next[k].num} =
                div2(st_reg[k-1].num, st_reg[k-1].rem, st_reg[k-1].div);
        end
    end

    // outlier count of the running frame, occlusion decided on its last pixel
    always_comb
    begin
        cnt_next = cnt_reg + 17'((st_reg[2].phase == rgbm_pkg::PH_CONT) && !st_reg[2].inl);
        occl_c   = (st_reg[2].phase == rgbm_pkg::PH_CONT) && st_reg[2].last &&
                   (25'(cnt_next) * 25'd100 >= occl_lim);
    end

    // final model of the item, written back
    always_comb
    begin
        e_q  = st_reg[NST-1].num;
        e_vw = clamp_var($signed({2'b0, e_q}) - $signed({11'd0, st_reg[NST-1].msq}));
        e_next.x     = st_reg[NST-1].x;
        e_next.phase = st_reg[NST-1].phase;
        e_next.last  = st_reg[NST-1].last;
        e_next.warm  = st_reg[NST-1].warm;
        e_next.occl  = st_reg[NST-1].occl;
        e_next.mu    = st_reg[NST-1].mu;
        e_next.vr    = st_reg[NST-1].vr;
        wr.data      = {st_reg[NST-1].mom, st_reg[NST-1].vr, st_reg[NST-1].mu};
        case (st_reg[NST-1].phase)
            rgbm_pkg::PH_SEED:
            begin
                e_next.mu = st_reg[NST-1].x;
                e_next.vr = rgbm_pkg::VAR_FLOOR;
                wr.data   = {32'(st_reg[NST-1].sq16), rgbm_pkg::VAR_FLOOR, st_reg[NST-1].x};
            end
            rgbm_pkg::PH_WARM:
            begin
                e_next.mu = st_reg[NST-1].mu_w;
                e_next.vr = e_vw;
                wr.data   = {st_reg[NST-1].m, e_vw, st_reg[NST-1].mu_w};
            end
            default:
            begin
                if (st_reg[NST-1].inl)
                begin
                    e_next.mu = st_reg[NST-1].mu_c;
                    e_next.vr = st_reg[NST-1].var_c;
                    wr.data   = {st_reg[NST-1].mom, st_reg[NST-1].var_c, st_reg[NST-1].mu_c};
                end
            end
        endcase
        wr.we   = v_reg[NST-1] && adv;
        wr.addr = st_reg[NST-1].idx;
    end

    // outlier test against the updated model
    always_comb
    begin
        f_d  = $signed({e_reg.x[15], e_reg.x}) - $signed({e_reg.mu[15], e_reg.mu});
        f_ad = f_d[16] ? 16'(-f_d) : 16'(f_d);
        f_next.ad2   = 32'(f_ad) * 32'(f_ad);
        f_next.plo   = 40'(t2[15:0]) * 40'(e_reg.vr);
        f_next.phi   = 40'(t2[31:16]) * 40'(e_reg.vr);
        f_next.phase = e_reg.phase;
        f_next.last  = e_reg.last;
        f_next.warm  = e_reg.warm;
        f_next.occl  = e_reg.occl;

        g_sum = 57'(f_reg.plo) + (57'(f_reg.phi) << 16) + 57'hFFFF;
        g_thr = g_sum[56:16];
        res_next.outlier = (f_reg.phase != rgbm_pkg::PH_SEED) && (41'(f_reg.ad2) >= g_thr);
        res_next.last    = f_reg.last;
        res_next.occl    = f_reg.occl;
        res_next.warm    = f_reg.warm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            ev_reg    <= 1'b0;
            fv_reg    <= 1'b0;
            out_valid <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[NST-2:0], in_valid};
            ev_reg    <= v_reg[NST-1];
            fv_reg    <= ev_reg;
            out_valid <= fv_reg;
            if (v_reg[2])
                cnt_reg <= st_reg[2].last ? 17'd0 : cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
                st_reg[k] <= st_next[k];
            e_reg   <= e_next;
            f_reg   <= f_next;
            out_res <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/running_gaussian_background_model_top.sv =====
// Path: update pipeline, then model, test and output registers; all hold while
// the output waits. Throughput: one item per cycle when frame_pixels exceeds 20
// and the output is not held; in shorter frames an item waits until the previous
// one is written back, for the read-modify-write loop around the model memory.
// Reset: frame and pixel counters clear, registers take their defaults; the
// model memory is not cleared, entries are seeded by the first frame.
// Depends on rgbm_pkg and rgbm_calc.
`default_nettype none

module running_gaussian_background_model_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream: tdata[15:0] = norm_pixel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [0] is_outlier, [1] occlusion
    output logic             m_axis_tlast,  // frame_end
    output logic             m_axis_tuser,  // [0] warming_up
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int IDX_W = rgbm_pkg::IDX_W;
    localparam int LEN_W = rgbm_pkg::LEN_W;

    // configuration registers
    logic [LEN_W-1:0]       len_cfg_reg;
    logic [7:0]             warm_cfg_reg;
    logic [15:0]            thr_cfg_reg;
    logic [15:0]            rate_cfg_reg;
    logic [6:0]             pct_cfg_reg;
    // values derived from them, refreshed every cycle
    logic [31:0]            t2_reg;
    logic [rgbm_pkg::LIM_W-1:0] lim_reg;

    logic [LEN_W-1:0]       len_eff;
    logic [7:0]             fc_reg, fc_next;
    logic [IDX_W-1:0]       pix_reg, pix_next;

    logic                   accept;
    logic                   adv;
    logic                   busy;
    logic                   hazard;
    rgbm_pkg::front_t       item;
    logic [7:0]             fc_seen;

    // model memory: mean, variance, second moment per pixel
    logic [rgbm_pkg::WORD_W-1:0] model_mem [rgbm_pkg::MAX_PIXELS];
    logic [rgbm_pkg::WORD_W-1:0] rdata_reg;

    rgbm_pkg::wr_t          wr;
    logic                   res_valid;
    rgbm_pkg::res_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg  <= rgbm_pkg::RST_FRAME_PIXELS;
            warm_cfg_reg <= rgbm_pkg::RST_WARMUP;
            thr_cfg_reg  <= rgbm_pkg::RST_THRESHOLD;
            rate_cfg_reg <= rgbm_pkg::RST_RATE;
            pct_cfg_reg  <= rgbm_pkg::RST_OCCL_PCT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rgbm_pkg::REG_FRAME_PIXELS: len_cfg_reg  <= cfg_data;
                rgbm_pkg::REG_WARMUP:       warm_cfg_reg <= cfg_data[7:0];
                rgbm_pkg::REG_THRESHOLD:    thr_cfg_reg  <= cfg_data[15:0];
                rgbm_pkg::REG_RATE:         rate_cfg_reg <= cfg_data[15:0];
                rgbm_pkg::REG_OCCL_PCT:     pct_cfg_reg  <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // frame length: zero acts as one, oversize acts as the memory depth
    always_comb
    begin
        if (len_cfg_reg == '0)
            len_eff = LEN_W'(1);
        else if (len_cfg_reg > LEN_W'(rgbm_pkg::MAX_PIXELS))
            len_eff = LEN_W'(rgbm_pkg::MAX_PIXELS);
        else
            len_eff = len_cfg_reg;
    end

    // squared threshold and occlusion limit: outliers*100 >= (pct+1)*len
    always_ff @(posedge clk)
    begin
        t2_reg  <= 32'(thr_cfg_reg) * 32'(thr_cfg_reg);
        lim_reg <= rgbm_pkg::LIM_W'(8'(pct_cfg_reg) + 8'd1) * rgbm_pkg::LIM_W'(len_eff);
    end

    // advance the whole pipeline when the output register can take an item
    assign adv    = !m_axis_tvalid || m_axis_tready;
    // hold input while an earlier item of a short frame may touch the same entry
    assign hazard = (len_eff <= LEN_W'(rgbm_pkg::PRE_STAGES)) && busy;
    assign s_axis_tready = adv && !hazard;
    assign accept = s_axis_tvalid && s_axis_tready;

    // front end: pixel position, phase and frame bookkeeping
    always_comb
    begin
        item.idx  = pix_reg;
        item.x    = $signed(s_axis_tdata);
        item.last = (LEN_W'(pix_reg) + LEN_W'(1)) >= len_eff;
        if (fc_reg == '0)
            item.phase = rgbm_pkg::PH_SEED;
        else if (fc_reg < warm_cfg_reg)
            item.phase = rgbm_pkg::PH_WARM;
        else
            item.phase = rgbm_pkg::PH_CONT;
        item.div = (item.phase == rgbm_pkg::PH_WARM) ? fc_reg + 8'd1 : 8'd1;
        // a saturated frame count reports one below itself on frame end
        fc_seen   = (item.last && fc_reg == 8'hFF) ? 8'hFE : fc_reg;
        item.warm = fc_seen < warm_cfg_reg;

        fc_next  = fc_reg;
        pix_next = pix_reg;
        if (accept)
        begin
            if (item.last)
            begin
                pix_next = '0;
                if (fc_reg != 8'hFF)
                    fc_next = fc_reg + 8'd1;
            end
            else
            begin
                pix_next = pix_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= '0;
            pix_reg <= '0;
        end
        else
        begin
            fc_reg  <= fc_next;
            pix_reg <= pix_next;
        end
    end

    // read on accept, write back from the end of the update pipeline
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= model_mem[pix_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
            model_mem[wr.addr] <= wr.data;
    end

    rgbm_calc u_calc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (accept),
        .in_item   (item),
        .rdata     (rdata_reg),
        .t2        (t2_reg),
        .rate      (rate_cfg_reg),
        .occl_lim  (lim_reg),
        .busy      (busy),
        .wr        (wr),
        .out_valid (res_valid),
        .out_res   (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {6'd0, res.occl, res.outlier};
    assign m_axis_tlast  = res.last;
    assign m_axis_tuser  = res.warm;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for running_gaussian_background_model_top.
// Streams normalized pixels, predicts outlier, frame and occlusion flags per pixel.
// Depends on rgbm_pkg and the model top level.
`timescale 1ns / 1ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] norm_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] is_outlier, [1] occlusion
    logic        m_axis_tlast;   // frame_end
    logic        m_axis_tuser;   // [0] warming_up
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    running_gaussian_background_model_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    localparam int SEED_LEN   = 24;     // seed frame length; later frames never exceed it
    localparam int DRAIN_WAIT = 30;     // idle wait after the result queue empties
    localparam int HOLD_LEN   = 400;    // long receiver hold-off
    localparam int WD_LIMIT   = 20000;  // cycles with no item moving

    // predicted model state
    int          mean_mem [SEED_LEN];
    int unsigned var_mem  [SEED_LEN];
    int unsigned mom_mem  [SEED_LEN];
    int          frame_cnt;
    int          pix_idx;
    int          out_cnt;

    // predicted register contents
    int len_cfg;
    int warm_cfg;
    int thr_cfg;
    int rate_cfg;
    int pct_cfg;

    rgbm_pkg::res_t flag_q[$];  // expected result items, oldest first
    int   mismatches;
    bit   quiet;            // no idling on either side
    bit   hold_req;         // ask the receiver for a long hold-off
    bit   sending;

    // stimulus helpers
    logic [15:0] base_pix [SEED_LEN];
    bit          burst_frame;

    typedef struct {
        logic [15:0]    x;
        rgbm_pkg::res_t exp;
    } row_t;

    // Seed frame: extremes of the pixel field. In the seed frame no pixel is an
    // outlier, occlusion stays low and the block is warming up.
    row_t seed_rows [SEED_LEN] = '{
        '{16'h0000, 4'b0001}, '{16'h7FFF, 4'b0001}, '{16'h8000, 4'b0001},
        '{16'h0001, 4'b0001}, '{16'hFFFF, 4'b0001}, '{16'h1000, 4'b0001},
        '{16'hF000, 4'b0001}, '{16'h5555, 4'b0001}, '{16'hAAAA, 4'b0001},
        '{16'h0800, 4'b0001}, '{16'hF800, 4'b0001}, '{16'h7FFE, 4'b0001},
        '{16'h8001, 4'b0001}, '{16'h0400, 4'b0001}, '{16'h2000, 4'b0001},
        '{16'hE000, 4'b0001}, '{16'h0123, 4'b0001}, '{16'hFEDC, 4'b0001},
        '{16'h3333, 4'b0001}, '{16'hCCCC, 4'b0001}, '{16'h00FF, 4'b0001},
        '{16'hFF00, 4'b0001}, '{16'h1234, 4'b0001}, '{16'h4000, 4'b0101}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint round_shr16(input longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic int sat_mean(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return int'(v);
    endfunction

    function automatic int unsigned sat_var(input longint v);
        if (v < longint'(rgbm_pkg::VAR_FLOOR))
            return rgbm_pkg::VAR_FLOOR;
        if (v > longint'(rgbm_pkg::VAR_MAX))
            return rgbm_pkg::VAR_MAX;
        return int'(v);
    endfunction

    // (x-mean)^2 against T^2*var, rounded up to the Q.24 scale of the square
    function automatic bit far_out(input longint x, input int mu, input int unsigned v);
        longint d;
        longint thr;
        d   = x - mu;
        if (d < 0)
            d = -d;
        thr = (longint'(thr_cfg) * thr_cfg * longint'(v) + 65535) >>> 16;
        return d * d >= thr;
    endfunction

    // Advance the predicted model by one pixel and return its result item.
    function automatic rgbm_pkg::res_t model_pixel(input logic [15:0] raw);
        longint x;
        longint ax;
        longint sq;
        longint m;
        longint mu;
        longint msq;
        longint d;
        longint nv;
        int     len;
        int     idx;
        int     fc_out;
        bit     last;
        rgbm_pkg::res_t r;
        x   = longint'($signed(raw));
        ax  = (x < 0) ? -x : x;
        sq  = (ax * ax) >>> 8;
        len = len_cfg;
        idx = pix_idx;
        r   = '0;
        if (len == 0)
            len = 1;
        if (len > rgbm_pkg::MAX_PIXELS)
            len = rgbm_pkg::MAX_PIXELS;
        if (frame_cnt == 0)
        begin
            mean_mem[idx] = sat_mean(x);
            mom_mem[idx]  = int'(sq);
            var_mem[idx]  = rgbm_pkg::VAR_FLOOR;
        end
        else if (frame_cnt < warm_cfg)
        begin
            m  = longint'(mom_mem[idx]) + sq;
            if (m > 64'hFFFFFFFF)
                m = 64'hFFFFFFFF;
            mu  = mean_mem[idx];
            msq = (((mu < 0) ? -mu : mu) * ((mu < 0) ? -mu : mu)) >>> 8;
            mom_mem[idx]  = int'(m);
            var_mem[idx]  = sat_var(m / (frame_cnt + 1) - msq);
            mean_mem[idx] = sat_mean(mu + round_shr16((x - mu) * 6554));
            r.outlier     = far_out(x, mean_mem[idx], var_mem[idx]);
        end
        else
        begin
            mu = mean_mem[idx];
            if (!far_out(x, int'(mu), var_mem[idx]))
            begin
                d  = x - mu;
                ax = (d < 0) ? -d : d;
                nv = ((65536 - longint'(rate_cfg)) * var_mem[idx]
                      + longint'(rate_cfg) * ((ax * ax) >>> 8) + 32768) >>> 16;
                var_mem[idx]  = (nv > longint'(rgbm_pkg::VAR_MAX)) ?
                                rgbm_pkg::VAR_MAX : sat_var(nv);
                mean_mem[idx] = sat_mean(mu + round_shr16(d * rate_cfg));
            end
            else
                out_cnt = (out_cnt + 1) & 17'h1FFFF;
            r.outlier = far_out(x, mean_mem[idx], var_mem[idx]);
        end
        last = (idx + 1) >= len;
        if (last)
        begin
            if (frame_cnt >= warm_cfg && frame_cnt != 0)
                r.occl = (longint'(out_cnt) * 100) / len > pct_cfg;
            if (frame_cnt < 255)
                frame_cnt++;
            pix_idx = 0;
            out_cnt = 0;
        end
        else
            pix_idx = idx + 1;
        // the count after the step minus one at frame end, even when saturated
        fc_out = last ? frame_cnt - 1 : frame_cnt;
        r.last = last;
        r.warm = fc_out < warm_cfg;
        return r;
    endfunction

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [2:0] index, input logic [16:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            rgbm_pkg::REG_FRAME_PIXELS: len_cfg  = value;
            rgbm_pkg::REG_WARMUP:       warm_cfg = value[7:0];
            rgbm_pkg::REG_THRESHOLD:    thr_cfg  = value[15:0];
            rgbm_pkg::REG_RATE:         rate_cfg = value[15:0];
            rgbm_pkg::REG_OCCL_PCT:     pct_cfg  = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offer one pixel, with an optional idle burst first; on acceptance queue
    // its expected result (the typed one when given).
    task automatic send_pixel(input logic [15:0] x, input bit typed,
                              input rgbm_pkg::res_t exp);
        rgbm_pkg::res_t pred;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = x;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = model_pixel(x);
        flag_q.push_back(typed ? exp : pred);
        @(negedge clk);
    endtask

    // Pick the next pixel: mostly near the pixel's own background with small
    // noise, sometimes fully random, at the extremes, or a whole occluded frame.
    function automatic logic [15:0] next_pixel();
        int idx;
        int k;
        idx = pix_idx;
        if (idx == 0)
            burst_frame = ($urandom_range(0, 5) == 0);
        k = $urandom_range(0, 19);
        if (burst_frame || k == 0)
            return 16'($urandom);
        if (k == 1)
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (k == 2)
            base_pix[idx] = 16'($urandom);
        return base_pix[idx] + 16'($urandom_range(0, 96)) - 16'd48;
    endfunction

    // Let the pipeline empty before touching the registers.
    task automatic drain();
        wait (flag_q.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic run_pixels(input int count);
        repeat (count)
            send_pixel(next_pixel(), 1'b0, '0);
        s_axis_tvalid = 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                hold_req      = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // checker and watchdog
    int             stuck;
    rgbm_pkg::res_t got;
    rgbm_pkg::res_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{outlier: m_axis_tdata[0], last: m_axis_tlast,
                        occl: m_axis_tdata[1], warm: m_axis_tuser};
                if (flag_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result item %b", $realtime, got);
                end
                else
                begin
                    want = flag_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result item mismatch: expected outlier=%b ",
                                      "last=%b occl=%b warm=%b, got outlier=%b last=%b ",
                                      "occl=%b warm=%b"},
                                     $realtime, want.outlier, want.last, want.occl,
                                     want.warm, got.outlier, got.last, got.occl, got.warm);
                    end
                end
            end
            // count only while something should be moving
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stuck = 0;
            else if (sending || flag_q.size() != 0)
                stuck++;
            if (stuck >= WD_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = rgbm_pkg::REG_FRAME_PIXELS;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        sending       = 1'b1;
        mismatches    = 0;
        stuck         = 0;
        burst_frame   = 1'b0;
        frame_cnt     = 0;
        pix_idx       = 0;
        out_cnt       = 0;
        len_cfg       = rgbm_pkg::RST_FRAME_PIXELS;
        warm_cfg      = rgbm_pkg::RST_WARMUP;
        thr_cfg       = rgbm_pkg::RST_THRESHOLD;
        rate_cfg      = rgbm_pkg::RST_RATE;
        pct_cfg       = rgbm_pkg::RST_OCCL_PCT;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Frame length extremes first, then the seed length before any pixel.
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'h1FFFF);
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd0);
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd65536);
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'(SEED_LEN));
        write_reg(rgbm_pkg::REG_WARMUP, 17'd3);

        // directed seed frame
        foreach (seed_rows[i])
        begin
            base_pix[i] = seed_rows[i].x;
            send_pixel(seed_rows[i].x, 1'b1, seed_rows[i].exp);
        end
        s_axis_tvalid = 1'b0;

        // Warm-up into continuous mode at default threshold and rate.
        run_pixels(240);

        // Long warm-up again: counts below 255 fall back into warm-up.
        drain();
        write_reg(rgbm_pkg::REG_WARMUP, 17'd255);
        write_reg(rgbm_pkg::REG_RATE, 17'd0);
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd7);
        run_pixels(140);

        // One-pixel frames (length zero acts as one) saturate the frame count;
        // zero threshold makes every pixel an outlier.
        drain();
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd0);
        write_reg(rgbm_pkg::REG_THRESHOLD, 17'd0);
        write_reg(rgbm_pkg::REG_OCCL_PCT, 17'd0);
        run_pixels(270);

        // Largest threshold, rate and percentage.
        drain();
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd20);
        write_reg(rgbm_pkg::REG_THRESHOLD, 17'd65535);
        write_reg(rgbm_pkg::REG_RATE, 17'd65535);
        write_reg(rgbm_pkg::REG_OCCL_PCT, 17'd100);
        run_pixels(180);

        // Full-rate frames with a long receiver hold-off to back up the input.
        drain();
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'(SEED_LEN));
        write_reg(rgbm_pkg::REG_WARMUP, 17'd1);
        write_reg(rgbm_pkg::REG_THRESHOLD, 17'd8192);
        write_reg(rgbm_pkg::REG_RATE, 17'd6000);
        write_reg(rgbm_pkg::REG_OCCL_PCT, 17'd10);
        quiet    = 1'b1;
        hold_req = 1'b1;
        run_pixels(200);
        quiet = 1'b0;

        // random register settings
        repeat (4)
        begin
            drain();
            write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'($urandom_range(1, SEED_LEN)));
            write_reg(rgbm_pkg::REG_WARMUP, 17'($urandom_range(0, 255)));
            write_reg(rgbm_pkg::REG_THRESHOLD, 17'($urandom_range(0, 65535)));
            write_reg(rgbm_pkg::REG_RATE, 17'($urandom_range(0, 65535)));
            write_reg(rgbm_pkg::REG_OCCL_PCT, 17'($urandom_range(0, 100)));
            run_pixels(150);
        end

        // last stretch: no idling anywhere
        drain();
        write_reg(rgbm_pkg::REG_FRAME_PIXELS, 17'd22);
        write_reg(rgbm_pkg::REG_THRESHOLD, 17'd12288);
        write_reg(rgbm_pkg::REG_RATE, 17'd459);
        write_reg(rgbm_pkg::REG_OCCL_PCT, 17'd20);
        quiet = 1'b1;
        run_pixels(150);

        wait (flag_q.size() == 0);
        sending = 1'b0;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== running_gaussian_background_model_top.f =====
rtl/rgbm_pkg.sv
rtl/rgbm_calc.sv
rtl/running_gaussian_background_model_top.sv
test/tb.sv
